// ===== rtl/core/scan_channel_statistics_unit_macros.svh =====
// Assertion helpers for the scan channel statistics block.
`ifndef SCAN_CHANNEL_STATISTICS_UNIT_MACROS_SVH
`define SCAN_CHANNEL_STATISTICS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scs check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scs check failed");

`endif

// ===== rtl/core/scs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int N_LIM        = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
  localparam int NCNT_W       = $clog2(N_LIM + 1);
  localparam int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 32;
  localparam int AVG_W    = 24;
  localparam int SCAN_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CCNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } scs_in_t;

  typedef struct packed {
    logic [CH_W-1:0]     chan;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] maximum;
    logic [TOTAL_W-1:0]  total;
    logic [AVG_W-1:0]    average;
    logic [SCAN_W-1:0]   scans_done;
    logic                last;
  } scs_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic update;
    logic idx_clr;
    logic div_start;
    logic emit;
    logic idx_inc;
  } scs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic stop;
    logic div_done;
    logic idx_last;
    logic out_pending;
  } scs_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/scs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scs_div
  import scs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [TOTAL_W-1:0] total,
  input  wire logic [SCAN_W-1:0]  scans,
  output logic                    done,
  output logic [AVG_W-1:0]        quot
);

  localparam int STEP_W = $clog2(AVG_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AVG_W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SCAN_W-1:0]   rem_r, rem_nxt;
  logic [AVG_W-1:0]    sh_r, sh_nxt;
  logic [AVG_W-1:0]    q_r, q_nxt;
  logic [SCAN_W-1:0]   dvs_r, dvs_nxt;
  logic [SCAN_W:0]     trial;
  logic                ge;
  logic                sat;

  // Quotient exceeds 24 bits exactly when total >= scans * 2^16.
  assign sat   = total >= {scans, 16'h0000};
  assign trial = {rem_r, sh_r[AVG_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      dvs_nxt = scans;
      if (sat) begin
        q_nxt    = {AVG_W{1'b1}};
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = total[TOTAL_W-1 -: SCAN_W];
        sh_nxt   = {total[TOTAL_W-SCAN_W-1:0], 8'h00};
        q_nxt    = '0;
        step_nxt = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // one restoring step per cycle
      rem_nxt  = ge ? SCAN_W'(trial - {1'b0, dvs_r}) : trial[SCAN_W-1:0];
      sh_nxt   = {sh_r[AVG_W-2:0], 1'b0};
      q_nxt    = {q_r[AVG_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/scs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scs_datapath
  import scs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scs_cmd_t             cmd,
  output scs_sts_t                  sts,
  input  wire scs_in_t              in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output logic                      out_valid,
  output scs_out_t                  out_data
);

  logic [SCAN_W-1:0]   scan_count_r;
  logic [CCNT_W-1:0]   chan_count_r;
  scs_in_t             in_r;
  logic                running_r, running_nxt;
  logic [SCAN_W-1:0]   cnt_r, cnt_nxt;
  logic [CH_W-1:0]     idx_r, idx_nxt;
  logic [SAMPLE_W-1:0] min_r [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] max_r [MAX_CHANNELS];
  logic [TOTAL_W-1:0]  tot_r [MAX_CHANNELS];
  logic                out_valid_r;
  scs_out_t            out_r;

  logic [NCNT_W-1:0]   n_eff;
  logic [SCAN_W-1:0]   limit;
  logic [SCAN_W-1:0]   cnt_inc;
  logic                hit, scan_end, do_upd;
  logic [IDX_W-1:0]    wr_a, rd_a;
  logic [SAMPLE_W-1:0] new_min, new_max;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  new_tot;
  logic                div_done;
  logic [AVG_W-1:0]    div_q;

  // Clamp the channel count to 1 .. N_LIM.
  always_comb begin
    if (chan_count_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (CCNT_W'(chan_count_r) > CCNT_W'(N_LIM)) begin
      n_eff = NCNT_W'(N_LIM);
    end else begin
      n_eff = NCNT_W'(chan_count_r);
    end
  end

  assign limit    = (scan_count_r == '0) ? SCAN_W'(1) : scan_count_r;
  assign cnt_inc  = (cnt_r == {SCAN_W{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign hit      = (in_r.kind == KIND_SAMPLE) && running_r
                    && (NCNT_W'(in_r.channel) < n_eff);
  assign scan_end = hit && (NCNT_W'(in_r.channel) == n_eff - 1'b1);
  assign do_upd   = cmd.update && hit;

  assign wr_a = IDX_W'(in_r.channel);
  assign rd_a = IDX_W'(idx_r);

  always_comb begin
    sum = {1'b0, tot_r[wr_a]} + {{(TOTAL_W-SAMPLE_W+1){1'b0}}, in_r.sample};
    if (cnt_r == '0) begin
      new_min = in_r.sample;
      new_max = in_r.sample;
      new_tot = TOTAL_W'(in_r.sample);
    end else begin
      new_min = (in_r.sample < min_r[wr_a]) ? in_r.sample : min_r[wr_a];
      new_max = (in_r.sample > max_r[wr_a]) ? in_r.sample : max_r[wr_a];
      new_tot = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    end
  end

  always_comb begin
    running_nxt = running_r;
    cnt_nxt     = cnt_r;
    if (cmd.update) begin
      if (in_r.kind == KIND_RESTART) begin
        running_nxt = 1'b1;
        cnt_nxt     = '0;
      end else if (scan_end) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= limit) begin
          running_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_count_r <= SCAN_W'(1);
      chan_count_r <= CCNT_W'(8);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCAN_COUNT:    scan_count_r <= cfg_wdata;
        REG_CHANNEL_COUNT: chan_count_r <= cfg_wdata[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
        tot_r[i] <= '0;
      end
    end else begin
      running_r   <= running_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= cmd.emit;
      if (do_upd) begin
        min_r[wr_a] <= new_min;
        max_r[wr_a] <= new_max;
        tot_r[wr_a] <= new_tot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.emit) begin
      out_r.chan       <= idx_r;
      out_r.minimum    <= min_r[rd_a];
      out_r.maximum    <= max_r[rd_a];
      out_r.total      <= tot_r[rd_a];
      out_r.average    <= div_q;
      out_r.scans_done <= cnt_r;
      out_r.last       <= sts.idx_last;
    end
  end

  scs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .total (tot_r[rd_a]),
    .scans (cnt_r),
    .done  (div_done),
    .quot  (div_q)
  );

  assign sts.stop        = cmd.update && scan_end && (cnt_inc >= limit);
  assign sts.div_done    = div_done;
  assign sts.idx_last    = (NCNT_W'(idx_r) == n_eff - 1'b1);
  assign sts.out_pending = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/scs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scs_ctrl
  import scs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire scs_sts_t sts,
  output scs_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_UPDATE  = 5'b00010,
    S_DIVGO   = 5'b00100,
    S_DIVWAIT = 5'b01000,
    S_EMIT    = 5'b10000
  } scs_state_t;

  scs_state_t state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE) || sts.out_pending;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = accept;
        if (accept) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update  = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt   = sts.stop ? S_DIVGO : S_IDLE;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          // advance to the next channel
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DIVGO;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scan_channel_statistics_unit.sv =====
// A sample or restart word is accepted, then updated in the next cycle; busy is high
// one cycle when the word does not stop the run, so a new word waits for the update.
// A scan-ending word that stops the run gives one summary per active channel, one per
// run of the 24-step serial divider (which skips its steps when the average saturates).
// The receiver cannot stall: each summary shows for one cycle on out_valid.
// Reset (rst_n low, synchronous) zeroes all statistics, stops the block, scan_count=1.
`timescale 1ns / 1ps
`default_nettype none
module scan_channel_statistics_unit
  import scs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire scs_in_t              in_data,
  output logic                      out_valid,
  output scs_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  scs_cmd_t cmd;
  scs_sts_t sts;

  scs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  scs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/scs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "scan_channel_statistics_unit_macros.svh"
module scs_checker
  import scs_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire scs_out_t out_data
);

  // an accepted word always occupies the block for its update cycle
  `SCS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // summaries are spaced by the divider, never back to back
  `SCS_ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid, !out_valid)
  // a summary word holds the block until it has been shown
  `SCS_ASSERT_NOW(a_out_busy, clk, rst_n, out_valid, busy)
  // a run never ends with zero scans, and the burst continues until last
  `SCS_ASSERT_NOW(a_scans_nz, clk, rst_n, out_valid, out_data.scans_done != '0)
  `SCS_ASSERT_NEXT(a_burst_hold, clk, rst_n, out_valid && !out_data.last, busy)

endmodule

bind scan_channel_statistics_unit scs_checker u_scs_checker (.*);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import scs_pkg::*;

  localparam int SETTLE_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  scs_in_t              in_data = '0;
  logic                 out_valid;
  scs_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  scan_channel_statistics_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Statistics mirror and its register copies.
  logic [SAMPLE_W-1:0] stat_lo  [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] stat_hi  [MAX_CHANNELS];
  logic [TOTAL_W-1:0]  stat_sum [MAX_CHANNELS];
  logic [SCAN_W-1:0]   scan_ctr = '0;
  logic                run_on = 1'b0;
  logic [SCAN_W-1:0]   cfg_scans = 16'd1;
  logic [CCNT_W-1:0]   cfg_chans = 4'd8;

  scs_in_t  pending_words[$];
  scs_out_t summary_queue[$];
  int unsigned send_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned words_taken = 0;
  int unsigned summaries_seen = 0;
  int unsigned settings_used = 0;

  function automatic int unsigned live_channels();
    if (cfg_chans == 0) return 1;
    if (cfg_chans > N_LIM) return N_LIM;
    return cfg_chans;
  endfunction

  function automatic void predict_summaries(scs_in_t w);
    int unsigned n;
    int unsigned limit;
    logic [TOTAL_W:0] sum;
    logic [39:0] quo;
    scs_out_t r;
    if (w.kind == KIND_RESTART) begin
      scan_ctr = '0;
      run_on = 1'b1;
      return;
    end
    if (!run_on) return;
    n = live_channels();
    if (w.channel >= n) return;
    if (scan_ctr == 0) begin
      stat_lo[w.channel] = w.sample;
      stat_hi[w.channel] = w.sample;
      stat_sum[w.channel] = TOTAL_W'(w.sample);
    end else begin
      if (w.sample < stat_lo[w.channel]) stat_lo[w.channel] = w.sample;
      if (w.sample > stat_hi[w.channel]) stat_hi[w.channel] = w.sample;
      sum = {1'b0, stat_sum[w.channel]} + w.sample;
      stat_sum[w.channel] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end
    if (w.channel != n - 1) return;
    // end of scan
    if (scan_ctr != '1) scan_ctr = scan_ctr + 1'b1;
    limit = (cfg_scans == 0) ? 1 : cfg_scans;
    if (scan_ctr < limit) return;
    run_on = 1'b0;
    for (int i = 0; i < n; i++) begin
      quo = {stat_sum[i], 8'h00} / scan_ctr;
      r.chan       = CH_W'(i);
      r.minimum    = stat_lo[i];
      r.maximum    = stat_hi[i];
      r.total      = stat_sum[i];
      r.average    = (quo > 40'hFF_FFFF) ? '1 : quo[AVG_W-1:0];
      r.scans_done = scan_ctr;
      r.last       = (i == n - 1);
      summary_queue.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : word_driver
    logic took;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        predict_summaries(in_data);
        words_taken++;
      end
      if (!start || took) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : summary_monitor
    scs_out_t want;
    if (rst_n && out_valid) begin
      summaries_seen++;
      if (summary_queue.size() == 0) begin
        error_count++;
        $error("unexpected summary for chan %0d", out_data.chan);
      end else begin
        want = summary_queue.pop_front();
        check_field("chan", want.chan, out_data.chan);
        check_field("minimum", want.minimum, out_data.minimum);
        check_field("maximum", want.maximum, out_data.maximum);
        check_field("total", want.total, out_data.total);
        check_field("average", want.average, out_data.average);
        check_field("scans_done", want.scans_done, out_data.scans_done);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  function automatic void queue_word(logic kind, int unsigned ch, logic [SAMPLE_W-1:0] s);
    scs_in_t w;
    w.kind    = kind;
    w.channel = CH_W'(ch);
    w.sample  = s;
    pending_words.push_back(w);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One run: restart, then in-order scans, with stray words mixed in.
  task automatic queue_run(int unsigned n, int unsigned scans);
    queue_word(KIND_RESTART, $urandom_range(7), SAMPLE_W'($urandom));
    for (int s = 0; s < scans; s++) begin
      for (int c = 0; c < n; c++) begin
        if ($urandom_range(99) < 8)
          queue_word(KIND_SAMPLE, (n < 8) ? $urandom_range(7, n) : $urandom_range(n - 1),
                     rand_sample());
        if ($urandom_range(99) < 2)
          queue_word(KIND_RESTART, $urandom_range(7), SAMPLE_W'($urandom));
        queue_word(KIND_SAMPLE, c, rand_sample());
      end
    end
    // sample while stopped
    if ($urandom_range(99) < 25) queue_word(KIND_SAMPLE, $urandom_range(7), rand_sample());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SCAN_COUNT) cfg_scans = value;
    else cfg_chans = value[CCNT_W-1:0];
    settings_used++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || start || summary_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned idle_mix[4];
    int unsigned rand_words;
    int unsigned setting;
    int unsigned chans;
    int unsigned scans;
    idle_mix = '{0, 67, 0, 26};
    rand_words = 0;
    setting = 0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      stat_lo[i] = '0;
      stat_hi[i] = '0;
      stat_sum[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one scan over all eight channels, field extremes.
    queue_word(KIND_SAMPLE, 0, 16'hFFFF);
    queue_word(KIND_RESTART, 0, 16'h0000);
    queue_word(KIND_SAMPLE, 0, 16'h0000);
    queue_word(KIND_SAMPLE, 1, 16'hFFFF);
    queue_word(KIND_SAMPLE, 2, 16'h5555);
    queue_word(KIND_SAMPLE, 3, 16'hAAAA);
    queue_word(KIND_SAMPLE, 4, 16'h0001);
    queue_word(KIND_SAMPLE, 5, 16'h8000);
    queue_word(KIND_SAMPLE, 6, 16'h7FFF);
    queue_word(KIND_SAMPLE, 7, 16'hFFFE);
    queue_word(KIND_SAMPLE, 7, 16'h1234);
    wait_drained();

    // Zero channel count and zero scan count both act as one.
    write_reg(REG_CHANNEL_COUNT, 16'hFFF0);
    write_reg(REG_SCAN_COUNT, 16'h0000);
    queue_word(KIND_RESTART, 7, 16'hFFFF);
    queue_word(KIND_SAMPLE, 5, 16'h4321);
    queue_word(KIND_SAMPLE, 0, 16'h1234);
    wait_drained();

    // Reseed before the first scan ends, restart mid-run, out-of-order samples,
    // average saturation on channel zero.
    write_reg(REG_CHANNEL_COUNT, 16'd3);
    write_reg(REG_SCAN_COUNT, 16'd2);
    queue_word(KIND_RESTART, 0, 16'h0000);
    queue_word(KIND_SAMPLE, 0, 16'hFFFF);
    queue_word(KIND_SAMPLE, 0, 16'hFFFF);
    queue_word(KIND_SAMPLE, 1, 16'h0001);
    queue_word(KIND_SAMPLE, 2, 16'h0002);
    queue_word(KIND_RESTART, 3, 16'h0000);
    queue_word(KIND_SAMPLE, 0, 16'h8000);
    queue_word(KIND_SAMPLE, 1, 16'h0000);
    queue_word(KIND_SAMPLE, 2, 16'hFFFF);
    queue_word(KIND_SAMPLE, 0, 16'hFFFF);
    queue_word(KIND_SAMPLE, 0, 16'hFFFF);
    queue_word(KIND_SAMPLE, 2, 16'h0000);
    wait_drained();

    while (rand_words < 130) begin
      send_idle_pct = idle_mix[setting % 4];
      case ($urandom_range(5))
        0:       chans = 0;
        1:       chans = 1;
        2:       chans = 8;
        3:       chans = $urandom_range(15, 9);
        default: chans = $urandom_range(7, 2);
      endcase
      case ($urandom_range(4))
        0:       scans = 0;
        1:       scans = 1;
        default: scans = $urandom_range(4, 2);
      endcase
      write_reg(REG_CHANNEL_COUNT, (CFG_W'($urandom) & 16'hFFF0) | CFG_W'(chans));
      write_reg(REG_SCAN_COUNT, CFG_W'(scans));
      repeat ($urandom_range(3, 1)) begin
        queue_run(live_channels(), (scans == 0) ? 1 : scans);
        rand_words += live_channels() * ((scans == 0) ? 1 : scans) + 1;
      end
      wait_drained();
      setting++;
    end

    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    $display("Took %0d input words over %0d register writes, checked %0d channel summaries.",
             words_taken, settings_used, summaries_seen);
    $display("Runs included seeding, restarts, stray channels, zero settings and a clipped mean.");
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d words pending, %0d summaries outstanding.",
             pending_words.size(), summary_queue.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
